/* hw/rtl/lct5_pkg.sv */
package lct5_pkg;

    // Vocabulary limit: the entry count saturates here, the running index one below it.
    localparam int VOCAB_MAX  = 262144;
    // Number of ranked slots in the cell chain.
    localparam int TOP_K      = 5;

    localparam int VALUE_W    = 16;
    localparam int DIFF_W     = 16;
    localparam int INDEX_W    = 18;
    localparam int COUNT_W    = $clog2(VOCAB_MAX + 1);
    localparam int RANK_W     = 3;
    localparam int SQ_W       = 32;
    localparam int SQUARE_W   = 31;
    localparam int PROD_W     = 32;
    localparam int ABS_SUM_W  = 34;
    localparam int SQ_SUM_W   = 50;
    localparam int DOT_W      = 50;
    localparam int ENERGY_W   = 49;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_BITS   = RANK_W + INDEX_W + VALUE_W + DIFF_W + INDEX_W + ABS_SUM_W
                              + SQ_SUM_W + DOT_W + ENERGY_W + ENERGY_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    // One ranked entry.
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } slot_t;

    // What a cell shows its lower-ranked neighbour.
    typedef struct packed {
        slot_t slot;
        logic  ahead;
    } link_t;

    // Running statistics of one vector.
    typedef struct packed {
        logic [DIFF_W-1:0]       max_difference;
        logic [INDEX_W-1:0]      max_difference_index;
        logic [ABS_SUM_W-1:0]    sum_abs;
        logic [SQ_SUM_W-1:0]     sum_sq;
        logic signed [DOT_W-1:0] dot;
        logic [ENERGY_W-1:0]     logit_energy;
        logic [ENERGY_W-1:0]     reference_energy;
    } stats_t;

    localparam slot_t EMPTY_SLOT = '{valid: 1'b0,
                                     value: {1'b1, {(VALUE_W-1){1'b0}}},
                                     index: '0};

    localparam link_t HEAD_LINK = '{slot: '{valid: 1'b1,
                                           value: {1'b0, {(VALUE_W-1){1'b1}}},
                                           index: '0},
                                    ahead: 1'b1};

endpackage

/* hw/rtl/lct5_cell.sv */
module lct5_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               upd,
    input  logic                               clear,
    input  logic                               capture,
    input  logic                               pop,
    input  logic signed [lct5_pkg::VALUE_W-1:0] new_value,
    input  logic [lct5_pkg::INDEX_W-1:0]       new_index,
    input  lct5_pkg::link_t                    prev_link,
    output lct5_pkg::link_t                    link,
    input  lct5_pkg::slot_t                    frozen_in,
    output lct5_pkg::slot_t                    frozen_out
);
    import lct5_pkg::*;

    slot_t live_reg;
    slot_t live_next;
    slot_t frozen_reg;
    logic  ahead;

    // An equal value stays ahead, so the earlier item keeps the better rank.
    assign ahead = live_reg.valid && (live_reg.value >= new_value);

    always_comb begin
        if (ahead) begin
            live_next = live_reg;
        end else if (prev_link.ahead) begin
            live_next = '{valid: 1'b1, value: new_value, index: new_index};
        end else begin
            live_next = prev_link.slot;
        end
    end

    assign link       = '{slot: live_reg, ahead: ahead};
    assign frozen_out = frozen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg   <= EMPTY_SLOT;
            frozen_reg <= EMPTY_SLOT;
        end else begin
            if (upd) begin
                live_reg <= clear ? EMPTY_SLOT : live_next;
            end
            if (capture) begin
                frozen_reg <= live_next;
            end else if (pop) begin
                frozen_reg <= frozen_in;
            end
        end
    end

endmodule

/* hw/rtl/lct5_stats.sv */
module lct5_stats (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               upd,
    input  logic                               clear,
    input  logic [lct5_pkg::DIFF_W-1:0]        diff,
    input  logic [lct5_pkg::INDEX_W-1:0]       index,
    input  logic [lct5_pkg::SQ_W-1:0]          diff_sq,
    input  logic [lct5_pkg::SQUARE_W-1:0]      logit_sq,
    input  logic [lct5_pkg::SQUARE_W-1:0]      reference_sq,
    input  logic signed [lct5_pkg::PROD_W-1:0] product,
    output lct5_pkg::stats_t                   stats_next
);
    import lct5_pkg::*;

    stats_t                  stats_reg;
    logic [ABS_SUM_W:0]      abs_wide;
    logic [SQ_SUM_W:0]       sq_wide;
    logic [ENERGY_W:0]       le_wide;
    logic [ENERGY_W:0]       re_wide;
    logic signed [DOT_W:0]   dot_wide;

    // Each sum saturates at the top of its width; the dot product at both ends.
    always_comb begin
        abs_wide = {1'b0, stats_reg.sum_abs} + (ABS_SUM_W + 1)'(diff);
        sq_wide  = {1'b0, stats_reg.sum_sq} + (SQ_SUM_W + 1)'(diff_sq);
        le_wide  = {1'b0, stats_reg.logit_energy} + (ENERGY_W + 1)'(logit_sq);
        re_wide  = {1'b0, stats_reg.reference_energy} + (ENERGY_W + 1)'(reference_sq);
        dot_wide = {stats_reg.dot[DOT_W-1], stats_reg.dot}
                 + {{(DOT_W + 1 - PROD_W){product[PROD_W-1]}}, product};

        stats_next = stats_reg;
        if (diff > stats_reg.max_difference) begin
            stats_next.max_difference       = diff;
            stats_next.max_difference_index = index;
        end
        stats_next.sum_abs = abs_wide[ABS_SUM_W] ? '1 : abs_wide[ABS_SUM_W-1:0];
        stats_next.sum_sq  = sq_wide[SQ_SUM_W] ? '1 : sq_wide[SQ_SUM_W-1:0];
        stats_next.logit_energy = le_wide[ENERGY_W] ? '1 : le_wide[ENERGY_W-1:0];
        stats_next.reference_energy = re_wide[ENERGY_W] ? '1 : re_wide[ENERGY_W-1:0];
        if (dot_wide[DOT_W] != dot_wide[DOT_W-1]) begin
            stats_next.dot = dot_wide[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                             : {1'b0, {(DOT_W-1){1'b1}}};
        end else begin
            stats_next.dot = dot_wide[DOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= '0;
        end else if (upd) begin
            stats_reg <= clear ? '0 : stats_next;
        end
    end

endmodule

/* hw/rtl/logit_compare_with_top5_core.sv */
// Streaming comparison of a computed logit vector against a reference vector.
// Input channel (s_): one item per vector entry, tdata carries the computed and
// the reference logit (signed Q8.8) and tlast marks the final entry.
// Result channel (m_): after each final entry the block gives five items, one
// per rank of the five largest reference values (rank 0 first), each carrying
// the same statistics of the whole vector; tlast is high on rank four.
// The first result of a vector is valid once its last entry has passed both register
// stages and been captured; the other four follow one per cycle while m_tready is high.
// Throughput: one entry per cycle. Items flow through two register stages and
// the five ranking cells update all at once, so the only hold-up comes from the
// single result snapshot: a final entry that reaches the update stage while the
// previous vector's five results are still being taken waits there, and
// s_tready is low meanwhile. A stalled receiver therefore only backs up the
// input once a further vector has ended.
// Reset clears the entry counter, statistics, ranking cells and the snapshot's
// busy flag and rank; the block is ready for input in the first cycle after reset, and
// it returns to that state by itself after every final entry.
module logit_compare_with_top5_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] logit_value, [31:16] reference_value
    input  logic [lct5_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] rank, [20:3] token_index, [36:21] top_value, [52:37] max_difference,
    // [70:53] max_difference_index, [104:71] sum_abs_difference,
    // [154:105] sum_sq_difference, [204:155] dot_product, [253:205] logit_energy,
    // [302:254] reference_energy, [321:303] item_count, upper bits zero
    output logic [lct5_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import lct5_pkg::*;

    // Global advance: the pipeline holds only when a final entry cannot be
    // captured because the snapshot is still draining.
    logic adv;
    logic in_fire;
    logic upd;
    logic capture;
    logic pop;

    // Entry counter at the input.
    logic [COUNT_W-1:0]      cnt_reg;
    logic [COUNT_W-1:0]      cnt_after;
    logic [INDEX_W-1:0]      in_index;
    logic signed [VALUE_W-1:0] in_lv;
    logic signed [VALUE_W-1:0] in_rv;
    logic signed [DIFF_W:0]  in_d;
    logic [DIFF_W:0]         in_mag;

    // First stage: operands and absolute difference.
    logic                      p1_valid_reg;
    logic signed [VALUE_W-1:0] p1_lv_reg;
    logic signed [VALUE_W-1:0] p1_rv_reg;
    logic [DIFF_W-1:0]         p1_diff_reg;
    logic [INDEX_W-1:0]        p1_index_reg;
    logic [COUNT_W-1:0]        p1_count_reg;
    logic                      p1_last_reg;

    // Second stage: products registered before accumulation.
    logic                      p2_valid_reg;
    logic signed [VALUE_W-1:0] p2_rv_reg;
    logic [DIFF_W-1:0]         p2_diff_reg;
    logic [INDEX_W-1:0]        p2_index_reg;
    logic [COUNT_W-1:0]        p2_count_reg;
    logic                      p2_last_reg;
    logic [SQ_W-1:0]           p2_dsq_reg;
    logic [SQUARE_W-1:0]       p2_lsq_reg;
    logic [SQUARE_W-1:0]       p2_rsq_reg;
    logic signed [PROD_W-1:0]  p2_prod_reg;

    logic [SQ_W-1:0]           dsq_c;
    logic signed [PROD_W-1:0]  lsq_c;
    logic signed [PROD_W-1:0]  rsq_c;
    logic signed [PROD_W-1:0]  prod_c;

    // Result snapshot.
    stats_t              stats_next;
    stats_t              snap_stats_reg;
    logic [COUNT_W-1:0]  snap_count_reg;
    logic                snap_busy_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [INDEX_W-1:0]  out_index;
    logic [VALUE_W-1:0]  out_value;

    link_t links [TOP_K+1];
    slot_t frozen [TOP_K+1];

    assign adv      = !(p2_valid_reg && p2_last_reg && snap_busy_reg);
    assign s_tready = adv;
    assign in_fire  = s_tvalid && adv;
    assign upd      = p2_valid_reg && adv;
    assign capture  = upd && p2_last_reg;
    assign pop      = snap_busy_reg && m_tready;

    // Index of this entry saturates one below the vocabulary limit.
    always_comb begin
        in_lv  = s_tdata[VALUE_W-1:0];
        in_rv  = s_tdata[2*VALUE_W-1:VALUE_W];
        in_d   = {in_lv[VALUE_W-1], in_lv} - {in_rv[VALUE_W-1], in_rv};
        in_mag = in_d[DIFF_W] ? ((DIFF_W + 1)'(0) - in_d) : in_d;
        if (cnt_reg < COUNT_W'(VOCAB_MAX)) begin
            in_index  = cnt_reg[INDEX_W-1:0];
            cnt_after = cnt_reg + COUNT_W'(1);
        end else begin
            in_index  = INDEX_W'(VOCAB_MAX - 1);
            cnt_after = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (in_fire) begin
            cnt_reg <= s_tlast ? '0 : cnt_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_tvalid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    assign dsq_c  = p1_diff_reg * p1_diff_reg;
    assign lsq_c  = p1_lv_reg * p1_lv_reg;
    assign rsq_c  = p1_rv_reg * p1_rv_reg;
    assign prod_c = p1_lv_reg * p1_rv_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_lv_reg    <= in_lv;
            p1_rv_reg    <= in_rv;
            p1_diff_reg  <= in_mag[DIFF_W-1:0];
            p1_index_reg <= in_index;
            p1_count_reg <= cnt_after;
            p1_last_reg  <= s_tlast;

            p2_rv_reg    <= p1_rv_reg;
            p2_diff_reg  <= p1_diff_reg;
            p2_index_reg <= p1_index_reg;
            p2_count_reg <= p1_count_reg;
            p2_last_reg  <= p1_last_reg;
            p2_dsq_reg   <= dsq_c;
            p2_lsq_reg   <= lsq_c[SQUARE_W-1:0];
            p2_rsq_reg   <= rsq_c[SQUARE_W-1:0];
            p2_prod_reg  <= prod_c;
        end
    end

    lct5_stats u_stats (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd          (upd),
        .clear        (p2_last_reg),
        .diff         (p2_diff_reg),
        .index        (p2_index_reg),
        .diff_sq      (p2_dsq_reg),
        .logit_sq     (p2_lsq_reg),
        .reference_sq (p2_rsq_reg),
        .product      (p2_prod_reg),
        .stats_next   (stats_next)
    );

    // Ranking chain: cell 0 holds the largest reference value. Each cell sees
    // the new value and its upper neighbour; on pop the frozen copies shift
    // one place towards cell 0, which drives the result channel.
    assign links[0]      = HEAD_LINK;
    assign frozen[TOP_K] = EMPTY_SLOT;

    for (genvar i = 0; i < TOP_K; i++) begin : g_cell
        lct5_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .upd        (upd),
            .clear      (p2_last_reg),
            .capture    (capture),
            .pop        (pop),
            .new_value  (p2_rv_reg),
            .new_index  (p2_index_reg),
            .prev_link  (links[i]),
            .link       (links[i+1]),
            .frozen_in  (frozen[i+1]),
            .frozen_out (frozen[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            snap_stats_reg <= stats_next;
            snap_count_reg <= p2_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_busy_reg <= 1'b0;
            rank_reg      <= '0;
        end else if (capture) begin
            snap_busy_reg <= 1'b1;
            rank_reg      <= '0;
        end else if (pop) begin
            if (rank_reg == RANK_W'(TOP_K - 1)) begin
                snap_busy_reg <= 1'b0;
            end
            rank_reg <= rank_reg + RANK_W'(1);
        end
    end

    // A slot that no entry reached reads as index zero and the minimum value.
    assign out_index = frozen[0].valid ? frozen[0].index : '0;
    assign out_value = frozen[0].valid ? frozen[0].value : EMPTY_SLOT.value;

    assign m_tvalid = snap_busy_reg;
    assign m_tlast  = (rank_reg == RANK_W'(TOP_K - 1));
    assign m_tdata  = {{OUT_PAD_W{1'b0}},
                       snap_count_reg,
                       snap_stats_reg.reference_energy,
                       snap_stats_reg.logit_energy,
                       snap_stats_reg.dot,
                       snap_stats_reg.sum_sq,
                       snap_stats_reg.sum_abs,
                       snap_stats_reg.max_difference_index,
                       snap_stats_reg.max_difference,
                       out_value,
                       out_index,
                       rank_reg};

    // A new vector is only captured after the previous five results are gone.
    a_capture_free: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |-> !snap_busy_reg)
        else $error("final entry captured while results still pending");

    // Every capture opens a frame at rank zero.
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |=> (m_tvalid && (rank_reg == '0)))
        else $error("result frame did not start at rank zero");

    // The input is held back only while results wait at the output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && p2_valid_reg && p2_last_reg))
        else $error("input stalled without pending results");

    // Rank stays within the five slots.
    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rank_reg <= RANK_W'(TOP_K - 1)))
        else $error("rank beyond the last slot");

endmodule
